// File: hw/rtl/ps2mt_pkg.sv
// Shared constants, types and helper functions for the PS/2 mouse packet tracker.
package ps2mt_pkg;

    // Width of the internal cursor position registers
    localparam int COORD_BITS     = 9;
    // Width of the clamp limit registers and of the reported cursor fields
    localparam int LIMIT_BITS     = 9;
    localparam int CURSOR_BITS    = 9;
    localparam int BYTE_BITS      = 8;
    localparam int CFG_INDEX_BITS = 1;
    // Result beat: cursor_x, cursor_y, left, right, padded to whole bytes
    localparam int OUT_FIELD_BITS = 2 * CURSOR_BITS + 2;
    localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

    localparam logic [BYTE_BITS-1:0]  RESYNC_BYTE   = 8'hFA;
    localparam logic [LIMIT_BITS-1:0] X_LIMIT_RESET = 9'd320;
    localparam logic [LIMIT_BITS-1:0] Y_LIMIT_RESET = 9'd200;

    // Header byte bit positions
    localparam int HDR_LEFT_BIT  = 0;
    localparam int HDR_RIGHT_BIT = 1;
    localparam int HDR_XSIGN_BIT = 4;
    localparam int HDR_YSIGN_BIT = 5;

    // Divide by 20 as multiply by 205 / 4096; exact for magnitudes up to 256
    localparam int MAG_BITS     = BYTE_BITS + 1;
    localparam int QUOT_BITS    = 4;
    localparam int DIV20_MUL    = 205;
    localparam int DIV20_SHIFT  = 12;
    localparam int DIV20_PBITS  = MAG_BITS + 8;

    typedef enum logic [1:0] {
        PH_UNSYNC = 2'd0,
        PH_HEADER = 2'd1,
        PH_X      = 2'd2,
        PH_Y      = 2'd3
    } phase_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_X_LIMIT = 1'b0,
        REG_Y_LIMIT = 1'b1
    } cfg_reg_t;

    // Truncating divide of a movement magnitude by 20
    function automatic logic [QUOT_BITS-1:0] div20(input logic [MAG_BITS-1:0] mag);
        logic [DIV20_PBITS-1:0] prod;
        prod = DIV20_PBITS'(mag) * DIV20_PBITS'(DIV20_MUL);
        return QUOT_BITS'(prod >> DIV20_SHIFT);
    endfunction

endpackage

// File: hw/rtl/ps2_mouse_packet_tracker.sv
// Top level: PS/2 mouse byte stream to clamped cursor position and buttons.
// An accepted byte passes through the input register and then the result register.
// Throughput: one byte per cycle while the result side takes its beats; back-pressure stalls the input.
// Every accepted byte yields exactly one result beat; tlast marks a packet's Y byte.
// Reset: phase unsynchronised, cursor at 0,0, buttons released, limits 320 and 200.
// Configuration writes take effect at once and are always accepted.
module ps2_mouse_packet_tracker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // s_axis_tdata: [7:0] byte_in
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [ps2mt_pkg::BYTE_BITS-1:0]      s_axis_tdata,
    // m_axis_tdata: [8:0] cursor_x, [17:9] cursor_y, [18] left_pressed,
    //               [19] right_pressed, [23:20] zero
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [ps2mt_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,
    // m_axis_tlast: packet_done
    output logic                                 m_axis_tlast,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ps2mt_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [ps2mt_pkg::LIMIT_BITS-1:0]     cfg_data
);
    import ps2mt_pkg::*;

    // Input register
    logic                  in_valid_reg;
    logic [BYTE_BITS-1:0]  in_byte_reg;

    // Tracker state
    phase_t                phase_reg, phase_next;
    logic [COORD_BITS-1:0] pos_x_reg, pos_x_next;
    logic [COORD_BITS-1:0] pos_y_reg, pos_y_next;
    logic                  left_reg, left_next;
    logic                  right_reg, right_next;
    logic                  xneg_reg, xneg_next;
    logic                  yneg_reg, yneg_next;
    logic                  done_next;

    // Limit registers
    logic [LIMIT_BITS-1:0] x_limit_reg;
    logic [LIMIT_BITS-1:0] y_limit_reg;

    // Result register
    logic                   out_valid_reg;
    logic [CURSOR_BITS-1:0] cursor_x_reg;
    logic [CURSOR_BITS-1:0] cursor_y_reg;
    logic                   out_left_reg;
    logic                   out_right_reg;
    logic                   out_done_reg;

    logic                  out_load;
    logic                  advance;
    logic                  is_resync;
    logic [COORD_BITS-1:0] move_x_pos;
    logic [COORD_BITS-1:0] move_y_pos;

    // Handshake: result register frees when empty or taken
    assign out_load      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_load;
    assign s_axis_tready = !in_valid_reg || out_load;
    assign cfg_ready     = 1'b1;

    // Input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    // Capture the byte on an accepted beat
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    // Limit registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_limit_reg <= X_LIMIT_RESET;
            y_limit_reg <= Y_LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_X_LIMIT: x_limit_reg <= cfg_data;
                REG_Y_LIMIT: y_limit_reg <= cfg_data;
            endcase
        end
    end

    // Per-axis movement units
    ps2mt_move u_move_x (
        .pos       (pos_x_reg),
        .move_byte (in_byte_reg),
        .negative  (xneg_reg),
        .limit     (x_limit_reg),
        .pos_next  (move_x_pos)
    );

    ps2mt_move u_move_y (
        .pos       (pos_y_reg),
        .move_byte (in_byte_reg),
        .negative  (yneg_reg),
        .limit     (y_limit_reg),
        .pos_next  (move_y_pos)
    );

    assign is_resync = (in_byte_reg == RESYNC_BYTE);

    // Packet phase sequencing and state update
    always_comb
    begin
        phase_next = phase_reg;
        pos_x_next = pos_x_reg;
        pos_y_next = pos_y_reg;
        left_next  = left_reg;
        right_next = right_reg;
        xneg_next  = xneg_reg;
        yneg_next  = yneg_reg;
        done_next  = 1'b0;
        if (is_resync)
        begin
            phase_next = PH_HEADER;
        end
        else
        begin
            unique case (phase_reg)
                PH_UNSYNC:
                begin
                    phase_next = PH_UNSYNC;
                end
                PH_HEADER:
                begin
                    left_next  = in_byte_reg[HDR_LEFT_BIT];
                    right_next = in_byte_reg[HDR_RIGHT_BIT];
                    xneg_next  = in_byte_reg[HDR_XSIGN_BIT];
                    yneg_next  = in_byte_reg[HDR_YSIGN_BIT];
                    phase_next = PH_X;
                end
                PH_X:
                begin
                    pos_x_next = move_x_pos;
                    phase_next = PH_Y;
                end
                PH_Y:
                begin
                    pos_y_next = move_y_pos;
                    phase_next = PH_HEADER;
                    done_next  = 1'b1;
                end
            endcase
        end
    end

    // State registers advance once per byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_UNSYNC;
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            left_reg  <= 1'b0;
            right_reg <= 1'b0;
            xneg_reg  <= 1'b0;
            yneg_reg  <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
            left_reg  <= left_next;
            right_reg <= right_next;
            xneg_reg  <= xneg_next;
            yneg_reg  <= yneg_next;
        end
    end

    // Result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cursor_x_reg  <= CURSOR_BITS'(pos_x_next);
            cursor_y_reg  <= CURSOR_BITS'(pos_y_next);
            out_left_reg  <= left_next;
            out_right_reg <= right_next;
            out_done_reg  <= done_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DATA_BITS'({out_right_reg, out_left_reg,
                                           cursor_y_reg, cursor_x_reg});
    assign m_axis_tlast  = out_done_reg;

    // Unsynchronised phase can only leave towards the header phase
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_UNSYNC) |=> (phase_reg == PH_UNSYNC || phase_reg == PH_HEADER))
        else $error("phase left unsynchronised state other than via resync");

    // Horizontal position moves only on an X byte
    assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(pos_x_reg) |-> $past(advance && phase_reg == PH_X && !is_resync))
        else $error("pos_x changed outside an X byte");

    // Vertical position moves only on a Y byte
    assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(pos_y_reg) |-> $past(advance && phase_reg == PH_Y && !is_resync))
        else $error("pos_y changed outside a Y byte");

    // A completed packet is reported and the tracker returns to the header phase
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && phase_reg == PH_Y && !is_resync)
            |=> (out_valid_reg && out_done_reg && phase_reg == PH_HEADER))
        else $error("Y byte did not complete the packet");

endmodule

// File: hw/rtl/ps2mt_move.sv
// Movement update for one axis: scale the movement byte, add and clamp.
module ps2mt_move (
    input  logic [ps2mt_pkg::COORD_BITS-1:0] pos,
    input  logic [ps2mt_pkg::BYTE_BITS-1:0]  move_byte,
    input  logic                             negative,
    input  logic [ps2mt_pkg::LIMIT_BITS-1:0] limit,
    output logic [ps2mt_pkg::COORD_BITS-1:0] pos_next
);
    import ps2mt_pkg::*;

    localparam int SUM_BITS =
        ((COORD_BITS > LIMIT_BITS) ? COORD_BITS : LIMIT_BITS) + 2;
    localparam logic [SUM_BITS-1:0] CMAX = SUM_BITS'((1 << COORD_BITS) - 1);

    logic [MAG_BITS-1:0]  mag;
    logic [QUOT_BITS-1:0] quot;
    logic [SUM_BITS-1:0]  quot_ext;
    logic [SUM_BITS-1:0]  delta;
    logic [SUM_BITS-1:0]  limit_ext;
    logic [SUM_BITS-1:0]  bound;
    logic signed [SUM_BITS-1:0] sum;

    // Magnitude of the 9-bit signed movement, then truncate toward zero
    assign mag      = negative ? (MAG_BITS'(256) - MAG_BITS'(move_byte))
                               : MAG_BITS'(move_byte);
    assign quot     = div20(mag);
    assign quot_ext = SUM_BITS'(quot);
    assign delta    = negative ? (~quot_ext + SUM_BITS'(1)) : quot_ext;

    // Clamp bound is the smaller of the limit and the coordinate range
    assign limit_ext = SUM_BITS'(limit);
    assign bound     = (limit_ext > CMAX) ? CMAX : limit_ext;

    assign sum = $signed(SUM_BITS'(pos) + delta);

    // Clamp to 0..bound
    always_comb
    begin
        if (sum < 0)
        begin
            pos_next = '0;
        end
        else if ($unsigned(sum) > bound)
        begin
            pos_next = COORD_BITS'(bound);
        end
        else
        begin
            pos_next = COORD_BITS'($unsigned(sum));
        end
    end

endmodule

// File: tb/ps2_mouse_packet_tracker_tb.sv
// Testbench for the PS/2 mouse packet tracker: directed byte table, then predictor-checked packets.
`timescale 1ns / 100ps

module ps2_mouse_packet_tracker_tb;
    import ps2mt_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int LONG_HOLD     = 300;
    localparam int PHASE_ITEMS   = 265;
    localparam int RANDOM_PHASES = 6;
    localparam int MOVE_DIVISOR  = 20;
    localparam int DIRECTED_ROWS = 25;

    typedef struct packed {
        logic [CURSOR_BITS-1:0] cx;
        logic [CURSOR_BITS-1:0] cy;
        logic                   lb;
        logic                   rb;
        logic                   done;
    } cursor_beat_t;

    typedef struct packed {
        logic [BYTE_BITS-1:0] b;
        logic                 typed;
        cursor_beat_t         want;
    } byte_row_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    // s_axis_tdata: [7:0] byte_in
    logic [BYTE_BITS-1:0]      s_axis_tdata;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    // m_axis_tdata: [8:0] cursor_x, [17:9] cursor_y, [18] left_pressed,
    //               [19] right_pressed, [23:20] zero
    logic [OUT_DATA_BITS-1:0]  m_axis_tdata;
    // m_axis_tlast: packet_done
    logic                      m_axis_tlast;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [LIMIT_BITS-1:0]     cfg_data;

    // Predictor state
    phase_t                    pkt_phase;
    logic [COORD_BITS-1:0]     pos_x;
    logic [COORD_BITS-1:0]     pos_y;
    logic                      left_btn;
    logic                      right_btn;
    logic                      x_neg;
    logic                      y_neg;
    logic [LIMIT_BITS-1:0]     x_limit;
    logic [LIMIT_BITS-1:0]     y_limit;

    cursor_beat_t              cursor_due[$];
    int unsigned               mismatches    = 0;
    int unsigned               bytes_sent    = 0;
    int unsigned               send_gap_pct  = 31;
    int unsigned               recv_gap_pct  = 48;
    int unsigned               hold_requests = 0;

    byte_row_t                 byte_table [DIRECTED_ROWS] = '{
        // unsynchronised bytes change nothing
        '{8'h00, 1'b1, '{9'd0, 9'd0, 1'b0, 1'b0, 1'b0}},
        '{8'hFF, 1'b1, '{9'd0, 9'd0, 1'b0, 1'b0, 1'b0}},
        '{8'h7F, 1'b1, '{9'd0, 9'd0, 1'b0, 1'b0, 1'b0}},
        // first resync, then a header with both buttons
        '{8'hFA, 1'b1, '{9'd0, 9'd0, 1'b0, 1'b0, 1'b0}},
        '{8'h03, 1'b1, '{9'd0, 9'd0, 1'b1, 1'b1, 1'b0}},
        // largest positive moves
        '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        // largest negative moves
        '{8'h30, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        // resync where a header is expected
        '{8'hFA, 1'b0, '0},
        '{8'h10, 1'b0, '0},
        // resync where an X byte is expected
        '{8'hFA, 1'b0, '0},
        '{8'h10, 1'b0, '0},
        '{8'hEC, 1'b0, '0},
        // resync where a Y byte is expected
        '{8'hFA, 1'b0, '0},
        '{8'h21, 1'b0, '0},
        '{8'h13, 1'b0, '0},
        '{8'h01, 1'b0, '0},
        // exact divisor step on X, inexact step on Y
        '{8'h02, 1'b0, '0},
        '{8'h14, 1'b0, '0},
        '{8'hEB, 1'b0, '0},
        // header with the unused top bits set
        '{8'hFA, 1'b0, '0},
        '{8'hC0, 1'b0, '0},
        '{8'h80, 1'b0, '0}
    };

    ps2_mouse_packet_tracker dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Move one axis: sign-extend, divide toward zero, clamp to 0..limit
    function automatic logic [COORD_BITS-1:0] move_axis(
        input logic [COORD_BITS-1:0] pos,
        input logic [BYTE_BITS-1:0]  mv,
        input logic                  neg,
        input logic [LIMIT_BITS-1:0] lim
    );
        int step;
        int p;
        int bound;
        bound = (1 << COORD_BITS) - 1;
        if (int'(lim) < bound)
            bound = int'(lim);
        step = int'(mv);
        if (neg)
            step = step - 256;
        step = step / MOVE_DIVISOR;
        p = int'(pos) + step;
        if (p < 0)
            p = 0;
        if (p > bound)
            p = bound;
        return p[COORD_BITS-1:0];
    endfunction

    // Advance the tracker by one byte and return the cursor it reports
    function automatic cursor_beat_t track_byte(input logic [BYTE_BITS-1:0] b);
        cursor_beat_t beat;
        beat.done = 1'b0;
        if (b == RESYNC_BYTE)
        begin
            pkt_phase = PH_HEADER;
        end
        else
        begin
            case (pkt_phase)
                PH_HEADER:
                begin
                    left_btn  = b[HDR_LEFT_BIT];
                    right_btn = b[HDR_RIGHT_BIT];
                    x_neg     = b[HDR_XSIGN_BIT];
                    y_neg     = b[HDR_YSIGN_BIT];
                    pkt_phase = PH_X;
                end
                PH_X:
                begin
                    pos_x     = move_axis(pos_x, b, x_neg, x_limit);
                    pkt_phase = PH_Y;
                end
                PH_Y:
                begin
                    pos_y     = move_axis(pos_y, b, y_neg, y_limit);
                    pkt_phase = PH_HEADER;
                    beat.done = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
        beat.cx = pos_x[CURSOR_BITS-1:0];
        beat.cy = pos_y[CURSOR_BITS-1:0];
        beat.lb = left_btn;
        beat.rb = right_btn;
        return beat;
    endfunction

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Offer one byte, with random gaps, and log its cursor once accepted
    task automatic send_byte(
        input logic [BYTE_BITS-1:0] b,
        input logic                 typed = 1'b0,
        input cursor_beat_t         want  = '0
    );
        cursor_beat_t beat;
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        beat = track_byte(b);
        cursor_due.push_back(typed ? want : beat);
        bytes_sent++;
    endtask

    // Drop valid and hold until every cursor beat is back
    task automatic wait_quiet();
        s_axis_tvalid <= 1'b0;
        while (cursor_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_limits(input logic [LIMIT_BITS-1:0] xl, input logic [LIMIT_BITS-1:0] yl);
        cfg_valid <= 1'b1;
        cfg_index <= REG_X_LIMIT;
        cfg_data  <= xl;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        x_limit = xl;
        cfg_index <= REG_Y_LIMIT;
        cfg_data  <= yl;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        y_limit = yl;
        cfg_valid <= 1'b0;
    endtask

    // Result side: random back-pressure, one long hold on request, and the checks
    initial
    begin
        cursor_beat_t want;
        int unsigned  hold_served;
        int unsigned  hold_left;
        hold_served   = 0;
        hold_left     = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                if (cursor_due.size() == 0)
                begin
                    $display("%0t: unexpected beat: expected none, actual tdata=%h tlast=%b",
                             $time, m_axis_tdata, m_axis_tlast);
                    mismatches++;
                end
                else
                begin
                    want = cursor_due.pop_front();
                    check_field("cursor_x", 32'(want.cx),
                                32'(m_axis_tdata[CURSOR_BITS-1:0]));
                    check_field("cursor_y", 32'(want.cy),
                                32'(m_axis_tdata[2*CURSOR_BITS-1:CURSOR_BITS]));
                    check_field("left_pressed", 32'(want.lb),
                                32'(m_axis_tdata[2*CURSOR_BITS]));
                    check_field("right_pressed", 32'(want.rb),
                                32'(m_axis_tdata[2*CURSOR_BITS+1]));
                    check_field("padding", 0,
                                32'(m_axis_tdata[OUT_DATA_BITS-1:OUT_FIELD_BITS]));
                    check_field("packet_done", 32'(want.done), 32'(m_axis_tlast));
                end
            end
            if (hold_served != hold_requests)
            begin
                hold_left = LONG_HOLD;
                hold_served++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(0, 99) >= recv_gap_pct);
            end
        end
    end

    // Guard against a hung run
    initial
    begin
        for (int cycles = 0; cycles < CYCLE_LIMIT; cycles++)
            @(posedge clk);
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        logic [BYTE_BITS-1:0] hdr;
        int unsigned          pick;
        int unsigned          phase_start;
        logic                 rising;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_X_LIMIT;
        cfg_data      = '0;
        pkt_phase     = PH_UNSYNC;
        pos_x         = '0;
        pos_y         = '0;
        left_btn      = 1'b0;
        right_btn     = 1'b0;
        x_neg         = 1'b0;
        y_neg         = 1'b0;
        x_limit       = X_LIMIT_RESET;
        y_limit       = Y_LIMIT_RESET;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table at the reset limits
        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_byte(byte_table[i].b, byte_table[i].typed, byte_table[i].want);

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            wait_quiet();
            case (ph)
                0: set_limits(9'd511, 9'd511);
                1: set_limits(9'd0, 9'd0);
                2: set_limits(9'($urandom_range(100, 300)), 9'($urandom_range(100, 300)));
                3: set_limits(9'($urandom_range(0, 40)), 9'($urandom_range(0, 40)));
                4: set_limits(9'd511, 9'd0);
                default: set_limits(9'd0, 9'd511);
            endcase
            // Receiver slow first, then sender slow, then no gaps at all
            case (ph / 2)
                0:
                begin
                    send_gap_pct = 31;
                    recv_gap_pct = 48;
                end
                1:
                begin
                    send_gap_pct = 48;
                    recv_gap_pct = 31;
                end
                default:
                begin
                    send_gap_pct = 0;
                    recv_gap_pct = 0;
                end
            endcase
            if (ph == 1)
                hold_requests++;

            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                begin
                    send_byte(8'($urandom_range(0, 255)));
                end
                else if (pick == 1)
                begin
                    send_byte(RESYNC_BYTE);
                end
                else
                begin
                    // Well-formed packet, drifting up early in the phase and down later
                    if (pick == 2)
                        send_byte(RESYNC_BYTE);
                    rising = (bytes_sent - phase_start) < (PHASE_ITEMS * 3) / 5;
                    hdr = 8'($urandom_range(0, 255));
                    hdr[HDR_XSIGN_BIT] = rising ? ($urandom_range(0, 99) < 15)
                                                : ($urandom_range(0, 99) < 85);
                    hdr[HDR_YSIGN_BIT] = rising ? ($urandom_range(0, 99) < 15)
                                                : ($urandom_range(0, 99) < 85);
                    if (hdr == RESYNC_BYTE)
                        hdr[2] = 1'b1;
                    send_byte(hdr);
                    send_byte(8'($urandom_range(0, 255)));
                    send_byte(8'($urandom_range(0, 255)));
                end
            end
        end

        wait_quiet();
        if (mismatches == 0 && cursor_due.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
